@@ rtl/dqotf_pkg.sv @@
// Shared constants, types and tables of the on-off-keyed tone framer.
`default_nettype none

package dqotf_pkg;

    // Sizing of the datagram ring and of the tone.
    localparam int DATAGRAM_BYTES  = 32;
    localparam int QUEUE_DEPTH     = 32;
    localparam int SAMPLES_PER_BIT = 16;
    localparam int MAX_SYNC_BYTES  = 8;

    // Fixed field widths of the ports.
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;
    localparam int SAMPLE_W    = 16;
    localparam int QCOUNT_W    = 6;
    localparam int SYNC_W      = 64;
    localparam int SLEN_W      = 4;
    localparam int TCPB_W      = 4;
    localparam int CFG_IDX_W   = 2;

    // Derived widths.
    localparam int PTR_W    = $clog2(2 * QUEUE_DEPTH);
    localparam int PTR_W1   = PTR_W + 1;
    localparam int SLOT_W   = $clog2(QUEUE_DEPTH);
    localparam int FILL_W   = (DATAGRAM_BYTES > 1) ? $clog2(DATAGRAM_BYTES) : 1;
    localparam int RAM_DEPTH = QUEUE_DEPTH * DATAGRAM_BYTES;
    localparam int ADDR_W   = $clog2(RAM_DEPTH);
    localparam int FPOS_W   = $clog2(MAX_SYNC_BYTES + DATAGRAM_BYTES);
    localparam int TOT_W    = $clog2(MAX_SYNC_BYTES + DATAGRAM_BYTES + 1);
    localparam int SP_W     = $clog2(SAMPLES_PER_BIT);
    localparam int PHASE_W  = $clog2(SAMPLES_PER_BIT);
    localparam int PHASE_W1 = PHASE_W + 1;

    // Depth of the queue between the front and the back (a power of two).
    localparam int QUEUE_SLOTS = 4;
    localparam int QP_W        = $clog2(QUEUE_SLOTS);
    localparam int LVL_W       = $clog2(QUEUE_SLOTS + 1);

    // Sized constants.
    localparam logic [PTR_W:0]      RING_SPAN  = PTR_W1'(2 * QUEUE_DEPTH);
    localparam logic [PTR_W-1:0]    PTR_LAST   = PTR_W'(2 * QUEUE_DEPTH - 1);
    localparam logic [PTR_W-1:0]    PTR_HALF   = PTR_W'(QUEUE_DEPTH);
    localparam logic [FILL_W-1:0]   FILL_LAST  = FILL_W'(DATAGRAM_BYTES - 1);
    localparam logic [ADDR_W-1:0]   DB_ADDR    = ADDR_W'(DATAGRAM_BYTES);
    localparam logic [TOT_W-1:0]    DB_TOT     = TOT_W'(DATAGRAM_BYTES);
    localparam logic [SLEN_W-1:0]   SYNC_MAX   = SLEN_W'(MAX_SYNC_BYTES);
    localparam logic [SP_W-1:0]     SP_LAST    = SP_W'(SAMPLES_PER_BIT - 1);
    localparam logic [PHASE_W:0]    PHASE_SPAN = PHASE_W1'(SAMPLES_PER_BIT);
    localparam logic [LVL_W-1:0]    SLOTS_LVL  = LVL_W'(QUEUE_SLOTS);
    localparam logic [2:0]          BIT_FIRST  = 3'd7;
    localparam logic [SLEN_W-1:0]   SYNC_LEN_RESET = 4'd2;

    // Command codes carried in s_tuser.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_PATTERN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TONE_CYCLES  = 2'd2;

    // One classified item on its way from the front to the back.
    typedef struct packed {
        logic                tone_on;
        logic [PHASE_W-1:0]  phase;
        logic                frame_end;
        logic                write_ok;
        logic [QCOUNT_W-1:0] queue_count;
    } entry_t;

    typedef logic [SAMPLE_W-1:0] sine_table_t [SAMPLES_PER_BIT];
    typedef logic [PHASE_W-1:0]  step_table_t [2**TCPB_W];

    // Q1.15 sine of phase p out of SAMPLES_PER_BIT, by a quarter-wave polynomial.
    function automatic logic [SAMPLE_W-1:0] sine_q15(input int unsigned p);
        longint unsigned a;
        longint unsigned q;
        longint unsigned r;
        longint unsigned z2;
        longint unsigned t;
        longint unsigned y;
        a = ((longint'(p) * 65536 + SAMPLES_PER_BIT / 2) / SAMPLES_PER_BIT) & 64'hFFFF;
        q = a >> 14;
        r = a & 64'd16383;
        if ((q & 64'd1) != 0) begin
            r = 64'd16384 - r;
        end
        z2 = (r * r) >> 14;
        t  = 64'd21024 - ((64'd2320 * z2) >> 14);
        t  = 64'd51472 - ((t * z2) >> 14);
        y  = (t * r) >> 14;
        if (y > 64'd32767) begin
            y = 64'd32767;
        end
        if (q >= 2) begin
            return SAMPLE_W'((64'd65536 - y) & 64'hFFFF);
        end
        return SAMPLE_W'(y);
    endfunction

    function automatic sine_table_t build_sine_table();
        sine_table_t tbl;
        for (int i = 0; i < SAMPLES_PER_BIT; i++) begin
            tbl[i] = sine_q15(i);
        end
        return tbl;
    endfunction

    // Phase step per sample for each register value, reduced into one bit period.
    function automatic step_table_t build_step_table();
        step_table_t tbl;
        for (int i = 0; i < 2**TCPB_W; i++) begin
            tbl[i] = PHASE_W'(i % SAMPLES_PER_BIT);
        end
        return tbl;
    endfunction

    localparam sine_table_t SINE_TABLE      = build_sine_table();
    localparam step_table_t TONE_STEP_TABLE = build_step_table();

endpackage

`default_nettype wire

@@ rtl/dqotf_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module dqotf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/dqotf_front.sv @@
// Front end: accepts beats, runs the ring and frame counters, and classifies each item.
`default_nettype none

module dqotf_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dqotf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dqotf_pkg::SYNC_W-1:0]        cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [dqotf_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic [0:0]                          s_tuser,
    input  logic [dqotf_pkg::LVL_W-1:0]         queue_level,
    output logic                                push_valid,
    output dqotf_pkg::entry_t                   push_entry
);

    import dqotf_pkg::*;

    // Item waiting for the registered slot read.
    typedef struct packed {
        logic                from_ram;
        logic [2:0]          bit_sel;
        logic                pre_bit;
        logic [PHASE_W-1:0]  phase;
        logic                frame_end;
        logic                write_ok;
        logic [QCOUNT_W-1:0] queue_count;
    } pend_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_LAST) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_of(input logic [PTR_W-1:0] p);
        if (p >= PTR_HALF) begin
            return SLOT_W'(p - PTR_HALF);
        end
        return SLOT_W'(p);
    endfunction

    function automatic logic [PTR_W-1:0] queued_of(input logic [PTR_W-1:0] tail,
                                                   input logic [PTR_W-1:0] head);
        logic [PTR_W:0] wrap;
        wrap = (tail < head) ? RING_SPAN : '0;
        return PTR_W'({1'b0, tail} + wrap - {1'b0, head});
    endfunction

    // Configuration registers.
    logic [SYNC_W-1:0]  sync_pattern_reg;
    logic [SLEN_W-1:0]  sync_len_reg;
    logic [PHASE_W-1:0] tone_step_reg;

    // Ring and frame state.
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [FPOS_W-1:0]  pos_reg, pos_next;
    logic [2:0]         bit_reg, bit_next;
    logic [SP_W-1:0]    sp_reg, sp_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               has_reg, has_next;

    logic  pend_valid_reg;
    pend_t pend_reg;

    logic               accept;
    logic               is_tick;
    logic [PTR_W-1:0]   queued_cur;
    logic               ring_full;
    logic               frame_start;
    logic               has_now;
    logic [TOT_W-1:0]   pos_ext;
    logic [TOT_W-1:0]   sl_ext;
    logic [TOT_W-1:0]   data_off;
    logic [TOT_W-1:0]   frame_total;
    logic [TOT_W-1:0]   pos_inc;
    logic               in_sync;
    logic               in_data;
    logic [7:0]         sync_byte;
    logic               pre_bit;
    logic [PHASE_W:0]   phase_sum;
    logic [PHASE_W-1:0] phase_step;
    logic               wr_en;
    logic               rd_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [7:0]         rd_data;
    logic               frame_end;
    logic               write_ok;

    // Handshakes: room is reserved for the item still waiting on the slot read.
    assign cfg_ready = 1'b1;
    assign s_tready  = ({1'b0, queue_level} + {{LVL_W{1'b0}}, pend_valid_reg})
                       < {1'b0, SLOTS_LVL};
    assign accept    = s_tvalid && s_tready;
    assign is_tick   = (s_tuser[0] == CMD_TICK);

    // Ring occupancy.
    assign queued_cur = queued_of(tail_reg, head_reg);
    assign ring_full  = (queued_cur >= PTR_HALF);

    // Where the current bit comes from: sync byte, head slot or zero fill.
    assign frame_start = (pos_reg == '0) && (bit_reg == BIT_FIRST) && (sp_reg == '0);
    assign has_now     = frame_start ? (queued_cur != '0) : has_reg;
    assign pos_ext     = TOT_W'(pos_reg);
    assign sl_ext      = TOT_W'(sync_len_reg);
    assign in_sync     = (pos_ext < sl_ext);
    assign data_off    = pos_ext - sl_ext;
    assign in_data     = !in_sync && has_now && (data_off < DB_TOT);
    assign sync_byte   = sync_pattern_reg[{3'(pos_reg), 3'b000} +: 8];
    assign pre_bit     = in_sync && sync_byte[bit_reg];
    assign frame_total = sl_ext + DB_TOT;
    assign pos_inc     = pos_ext + 1'b1;

    // Tone phase advance, wrapped into one bit period.
    assign phase_sum  = {1'b0, phase_reg} + {1'b0, tone_step_reg};
    assign phase_step = (phase_sum >= PHASE_SPAN) ? PHASE_W'(phase_sum - PHASE_SPAN)
                                                  : PHASE_W'(phase_sum);

    // Slot store addresses.
    assign wr_addr = ADDR_W'(slot_of(tail_reg)) * DB_ADDR + ADDR_W'(fill_reg);
    assign rd_addr = ADDR_W'(slot_of(head_reg)) * DB_ADDR + ADDR_W'(data_off);

    // Next state for one accepted item.
    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        fill_next  = fill_reg;
        pos_next   = pos_reg;
        bit_next   = bit_reg;
        sp_next    = sp_reg;
        phase_next = phase_reg;
        has_next   = has_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        frame_end  = 1'b0;
        write_ok   = 1'b0;
        if (accept) begin
            if (!is_tick) begin
                if (!ring_full) begin
                    wr_en    = 1'b1;
                    write_ok = 1'b1;
                    if (fill_reg == FILL_LAST) begin
                        fill_next = '0;
                        tail_next = ptr_inc(tail_reg);
                    end else begin
                        fill_next = fill_reg + 1'b1;
                    end
                end
            end else begin
                rd_en      = in_data;
                has_next   = has_now;
                phase_next = phase_step;
                sp_next    = sp_reg + 1'b1;
                if (sp_reg == SP_LAST) begin
                    sp_next    = '0;
                    phase_next = '0;
                    if (bit_reg != 3'd0) begin
                        bit_next = bit_reg - 1'b1;
                    end else begin
                        bit_next = BIT_FIRST;
                        if (pos_inc >= frame_total) begin
                            frame_end = 1'b1;
                            pos_next  = '0;
                            has_next  = 1'b0;
                            if (has_now && (queued_cur != '0)) begin
                                head_next = ptr_inc(head_reg);
                            end
                        end else begin
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                end
            end
        end
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_pattern_reg <= '0;
            sync_len_reg     <= SYNC_LEN_RESET;
            tone_step_reg    <= TONE_STEP_TABLE[1];
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_SYNC_PATTERN: sync_pattern_reg <= cfg_data;
                CFG_SYNC_LENGTH: begin
                    sync_len_reg <= (cfg_data[SLEN_W-1:0] > SYNC_MAX) ? SYNC_MAX
                                                                      : cfg_data[SLEN_W-1:0];
                end
                CFG_TONE_CYCLES: tone_step_reg <= TONE_STEP_TABLE[cfg_data[TCPB_W-1:0]];
                default: ;
            endcase
        end
    end

    // Ring and frame counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg       <= '0;
            tail_reg       <= '0;
            fill_reg       <= '0;
            pos_reg        <= '0;
            bit_reg        <= BIT_FIRST;
            sp_reg         <= '0;
            phase_reg      <= '0;
            has_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            fill_reg       <= fill_next;
            pos_reg        <= pos_next;
            bit_reg        <= bit_next;
            sp_reg         <= sp_next;
            phase_reg      <= phase_next;
            has_reg        <= has_next;
            pend_valid_reg <= accept;
        end
    end

    // Classified item waits here while the slot byte is read.
    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_reg.from_ram    <= is_tick && in_data;
            pend_reg.bit_sel     <= bit_reg;
            pend_reg.pre_bit     <= is_tick && pre_bit;
            pend_reg.phase       <= phase_reg;
            pend_reg.frame_end   <= frame_end;
            pend_reg.write_ok    <= write_ok;
            pend_reg.queue_count <= QCOUNT_W'(queued_of(tail_next, head_next));
        end
    end

    dqotf_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_tdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Resolve the bit and hand the item to the queue.
    assign push_valid              = pend_valid_reg;
    assign push_entry.tone_on      = pend_reg.from_ram ? rd_data[pend_reg.bit_sel]
                                                       : pend_reg.pre_bit;
    assign push_entry.phase        = pend_reg.phase;
    assign push_entry.frame_end    = pend_reg.frame_end;
    assign push_entry.write_ok     = pend_reg.write_ok;
    assign push_entry.queue_count  = pend_reg.queue_count;

    // The ring never holds more than its depth of committed datagrams.
    a_ring_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        queued_cur <= PTR_HALF)
        else $error("datagram ring over its depth");

    // The fill index stays inside one datagram.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_LAST)
        else $error("fill index past datagram end");

    // A waiting item always finds room in the queue.
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> (queue_level < SLOTS_LVL))
        else $error("push into a full queue");

    // The sample after a frame end starts a fresh frame.
    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && frame_end) |=>
            (pos_reg == '0 && bit_reg == BIT_FIRST && sp_reg == '0 && !has_reg))
        else $error("frame counters not restarted after frame end");

endmodule

`default_nettype wire

@@ rtl/dqotf_queue.sv @@
// Short queue of classified items between the front and the back.
`default_nettype none

module dqotf_queue (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push_valid,
    input  dqotf_pkg::entry_t           push_entry,
    output logic                        pop_valid,
    input  logic                        pop_ready,
    output dqotf_pkg::entry_t           pop_entry,
    output logic [dqotf_pkg::LVL_W-1:0] level
);

    import dqotf_pkg::*;

    entry_t            slots [QUEUE_SLOTS];
    logic [QP_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QP_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0]  level_reg, level_next;
    logic              pop;

    assign pop_valid = (level_reg != '0);
    assign pop       = pop_valid && pop_ready;
    assign pop_entry = slots[rd_ptr_reg];
    assign level     = level_reg;

    // Pointer and fill level updates; the depth is a power of two so pointers wrap freely.
    always_comb begin
        wr_ptr_next = push_valid ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        level_next  = level_reg + {{(LVL_W-1){1'b0}}, push_valid}
                                - {{(LVL_W-1){1'b0}}, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push_valid) begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

@@ rtl/dqotf_back.sv @@
// Back end: turns queued items into output beats through an output register.
`default_nettype none

module dqotf_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                pop_valid,
    output logic                                pop_ready,
    input  dqotf_pkg::entry_t                   pop_entry,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dqotf_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                                m_tlast
);

    import dqotf_pkg::*;

    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_tdata_reg;
    logic                   out_tlast_reg;
    logic [SAMPLE_W-1:0]    sample;
    logic                   load;

    // Tone sample for a one bit, silence otherwise.
    assign sample    = pop_entry.tone_on ? SINE_TABLE[pop_entry.phase] : '0;
    assign pop_ready = !out_valid_reg || m_tready;
    assign load      = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload, packed from the lowest bit up.
    always_ff @(posedge aclk) begin
        if (load) begin
            out_tdata_reg <= {1'b0, pop_entry.queue_count, pop_entry.write_ok, sample};
            out_tlast_reg <= pop_entry.frame_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_tdata_reg;
    assign m_tlast  = out_tlast_reg;

endmodule

`default_nettype wire

@@ rtl/datagram_queue_ook_tone_framer_core.sv @@
// Top level of the on-off-keyed tone framer with its datagram ring. Write beats
// (s_tuser 0) load datagram bytes into a ring of slots, and tick beats (s_tuser 1)
// each produce one Q1.15 audio sample of the current frame: the sync bytes, then the
// head datagram or zeros, MSB first, a sine burst for a one and silence for a zero.
// Every input beat yields exactly one output beat. The block takes one beat per clock
// and keeps that rate while the output is held, until its four-entry internal queue
// fills; a beat's result passes the pending register and registered slot-store read,
// then the queue, then the output register. No clearing pass runs after reset.
`default_nettype none

module datagram_queue_ook_tone_framer_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dqotf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dqotf_pkg::SYNC_W-1:0]        cfg_data,
    // Input stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [dqotf_pkg::IN_TDATA_W-1:0]    s_tdata,   // [7:0] data_byte
    input  logic [0:0]                          s_tuser,   // [0] command
    // Result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dqotf_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [15:0] sample, [16] write_ok,
                                                           // [22:17] queue_count, [23] zero
    output logic                                m_tlast    // frame_end
);

    import dqotf_pkg::*;

    logic             push_valid;
    entry_t           push_entry;
    logic             pop_valid;
    logic             pop_ready;
    entry_t           pop_entry;
    logic [LVL_W-1:0] queue_level;

    dqotf_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .queue_level (queue_level),
        .push_valid  (push_valid),
        .push_entry  (push_entry)
    );

    dqotf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry),
        .level      (queue_level)
    );

    dqotf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
